// ----- hw/rtl/source_char_tokenizer_assert.svh -----
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SOURCE_CHAR_TOKENIZER_ASSERT_SVH
`define SOURCE_CHAR_TOKENIZER_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define SCT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sct_pkg.sv -----
// Shared constants, token record type and lookup functions for the tokenizer.
// No dependencies; imported by every tokenizer module.
package sct_pkg;

   localparam int LINE_BITS   = 16;
   localparam int LENGTH_BITS = 8;
   localparam int KIND_BITS   = 5;
   localparam int NUM_BITS    = 31;
   localparam int CHAR_BITS   = 8;
   localparam int PREFIX_CHARS = 5;
   localparam int PREFIX_BITS = PREFIX_CHARS * CHAR_BITS;
   localparam int KW_COUNT    = 8;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [KIND_BITS-1:0] KIND_EOF      = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_IDENT    = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_KW_FIRST = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_SEMI     = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_PLUS     = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_MINUS    = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_STAR     = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_SLASH    = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_LESS     = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_EQ       = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_EQEQ     = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_ERROR    = 5'd23;

   localparam logic [NUM_BITS-1:0] NUM_MAX = '1;

   // Keyword text, first character in the low byte, unused bytes zero.
   localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      40'h000074656C,   // let
      40'h0000006669,   // if
      40'h0065736C65,   // else
      40'h656C696877,   // while
      40'h746E697270,   // print
      40'h7475706E69,   // input
      40'h0065757274,   // true
      40'h65736C6166    // false
   };

   localparam logic [LENGTH_BITS-1:0] KW_LEN [KW_COUNT] = '{
      LENGTH_BITS'(3), LENGTH_BITS'(2), LENGTH_BITS'(4), LENGTH_BITS'(5),
      LENGTH_BITS'(5), LENGTH_BITS'(5), LENGTH_BITS'(4), LENGTH_BITS'(5)
   };

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [LINE_BITS-1:0]   line;
      logic [NUM_BITS-1:0]    value;
      logic [LENGTH_BITS-1:0] length;
      logic [CHAR_BITS-1:0]   bad;
      logic                   last;
   } sct_token_type;

   // Bytes above the stored length are always zero, so the whole prefix
   // and the length together identify a keyword.
   function automatic logic [KIND_BITS-1:0] ident_kind(
      input logic [PREFIX_BITS-1:0] prefix,
      input logic [LENGTH_BITS-1:0] len
   );
      logic [KIND_BITS-1:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (prefix == KW_TEXT[k] && len == KW_LEN[k]) begin
            kind = KIND_KW_FIRST + KIND_BITS'(k);
         end
      end
      return kind;
   endfunction

   // Single-character operators; anything else maps to the error kind.
   function automatic logic [KIND_BITS-1:0] punct_kind(input logic [CHAR_BITS-1:0] c);
      logic [KIND_BITS-1:0] kind;
      case (c)
         "(":     kind = KIND_LPAREN;
         ")":     kind = KIND_RPAREN;
         "{":     kind = KIND_LBRACE;
         "}":     kind = KIND_RBRACE;
         ";":     kind = KIND_SEMI;
         "+":     kind = KIND_PLUS;
         "-":     kind = KIND_MINUS;
         "*":     kind = KIND_STAR;
         "/":     kind = KIND_SLASH;
         "<":     kind = KIND_LESS;
         default: kind = KIND_ERROR;
      endcase
      return kind;
   endfunction

endpackage

// ----- hw/rtl/source_char_tokenizer.sv -----
// Source character tokenizer, top level.
// Depends on sct_pkg, sct_scan_core and sct_token_fifo.
//
// Usage: one source byte (or the end marker, req_is_end) is a beat on the
// req_ channel; tokens come out as beats on the rsp_ channel, each with its
// kind, line, length, number value and offending byte. rsp_last marks the
// final token caused by one input beat; a beat may cause none, one or two.
// Order: a byte accepted into the input register is scanned from there, its
// tokens enter the queue when the scanner steps, and then can be taken.
// Throughput: one input beat per cycle while the queue has room, set by the
// single-pass scan logic and the input register; output is one token per
// cycle out of a four-entry queue, so a run of two-token beats fills it.
// The scanner steps only while the queue has room for two tokens; when the
// receiver stalls the queue fills and req_ready falls after the input
// register is occupied.
// Reset (synchronous, active high) empties the queue and the input register
// and returns the scanner to idle on line one. After an error token or the
// end token the block keeps accepting beats but emits nothing until reset.
module source_char_tokenizer import sct_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CHAR_BITS-1:0]   req_ch,
   input  logic                   req_is_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [KIND_BITS-1:0]   rsp_token_kind,
   output logic [LINE_BITS-1:0]   rsp_line_number,
   output logic [NUM_BITS-1:0]    rsp_number_value,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic [CHAR_BITS-1:0]   rsp_bad_char,
   output logic                   rsp_last
);

   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] in_ch_ff;
   logic                 in_end_ff;
   logic                 step, space_ok, req_fire;
   logic [1:0]           tok_count;
   logic [1:0]           push_count;
   sct_token_type        tok0, tok1, head;

   assign step        = in_valid_ff && space_ok;
   assign req_ready   = !in_valid_ff || step;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !step);
   assign push_count  = step ? tok_count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_ch_ff  <= req_ch;
         in_end_ff <= req_is_end;
      end
   end

   sct_scan_core u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_ch     (in_ch_ff),
      .in_end    (in_end_ff),
      .tok_count (tok_count),
      .tok0      (tok0),
      .tok1      (tok1)
   );

   sct_token_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (tok0),
      .push1      (tok1),
      .space_ok   (space_ok),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_tok    (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_line_number  = head.line;
   assign rsp_number_value = head.value;
   assign rsp_token_length = head.length;
   assign rsp_bad_char     = head.bad;
   assign rsp_last         = head.last;

endmodule

// ----- hw/rtl/sct_scan_core.sv -----
// Scanner state and per-character token logic for the tokenizer.
// Depends on sct_pkg; produces up to two tokens per character beat.
module sct_scan_core import sct_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [CHAR_BITS-1:0] in_ch,
   input  logic                 in_end,
   output logic [1:0]           tok_count,
   output sct_token_type        tok0,
   output sct_token_type        tok1
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_EQ,
      MODE_STOP
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [NUM_BITS-1:0]    acc_ff, acc_in;
   logic [PREFIX_BITS-1:0] prefix_ff, prefix_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;

   logic                   is_digit, is_alpha;
   logic [3:0]             digit;
   logic [NUM_BITS+3:0]    acc_next;
   logic [LENGTH_BITS-1:0] len_inc;
   logic [LINE_BITS-1:0]   line_inc;
   logic                   pend_valid;
   sct_token_type          pend_tok, new_tok;
   logic                   flush_en, new_en, classify;
   logic [KIND_BITS-1:0]   pkind;

   always_comb begin
      is_digit = (in_ch >= "0") && (in_ch <= "9");
      is_alpha = ((in_ch >= "a") && (in_ch <= "z")) ||
                 ((in_ch >= "A") && (in_ch <= "Z")) || (in_ch == "_");
      digit    = 4'(in_ch - "0");
      // acc * 10 + digit, as two shifts and two adds.
      acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + (NUM_BITS+4)'(digit);
      len_inc  = (len_ff != '1) ? len_ff + 1'b1 : len_ff;
      line_inc = (line_ff != '1) ? line_ff + 1'b1 : line_ff;
      pkind    = punct_kind(in_ch);
   end

   // Token held by a pending mode, emitted when the lexeme ends.
   always_comb begin
      pend_valid = 1'b0;
      pend_tok   = '0;
      pend_tok.line = line_ff;
      unique case (mode_ff)
         MODE_IDENT: begin
            pend_valid      = 1'b1;
            pend_tok.kind   = ident_kind(prefix_ff, len_ff);
            pend_tok.length = len_ff;
         end
         MODE_NUMBER: begin
            pend_valid      = 1'b1;
            pend_tok.kind   = KIND_NUMBER;
            pend_tok.value  = acc_ff;
            pend_tok.length = len_ff;
         end
         MODE_SLASH: begin
            pend_valid      = 1'b1;
            pend_tok.kind   = KIND_SLASH;
            pend_tok.length = LENGTH_BITS'(1);
         end
         MODE_EQ: begin
            pend_valid      = 1'b1;
            pend_tok.kind   = KIND_EQ;
            pend_tok.length = LENGTH_BITS'(1);
         end
         default: pend_valid = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      line_in   = line_ff;
      flush_en  = 1'b0;
      new_en    = 1'b0;
      classify  = 1'b0;
      new_tok   = '0;
      new_tok.line = line_ff;

      if (mode_ff == MODE_STOP) begin
         flush_en = 1'b0;
      end else if (in_end) begin
         flush_en  = pend_valid;
         new_en    = 1'b1;
         new_tok.kind = KIND_EOF;
         mode_in   = MODE_STOP;
         acc_in    = '0;
         prefix_in = '0;
         len_in    = '0;
      end else begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  if (len_ff < LENGTH_BITS'(PREFIX_CHARS)) begin
                     prefix_in[{len_ff[2:0], 3'b000} +: CHAR_BITS] = in_ch;
                  end
                  len_in = len_inc;
               end else begin
                  flush_en = 1'b1;
                  classify = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  acc_in = (acc_next > (NUM_BITS+4)'(NUM_MAX)) ? NUM_MAX
                                                               : acc_next[NUM_BITS-1:0];
                  len_in = len_inc;
               end else begin
                  flush_en = 1'b1;
                  classify = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (in_ch == "/") begin
                  mode_in = MODE_COMMENT;
               end else begin
                  flush_en = 1'b1;
                  classify = 1'b1;
               end
            end
            MODE_EQ: begin
               if (in_ch == "=") begin
                  new_en         = 1'b1;
                  new_tok.kind   = KIND_EQEQ;
                  new_tok.length = LENGTH_BITS'(2);
                  mode_in        = MODE_IDLE;
               end else begin
                  flush_en = 1'b1;
                  classify = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (in_ch == "\n") begin
                  line_in = line_inc;
                  mode_in = MODE_IDLE;
               end
            end
            default: classify = 1'b1;
         endcase

         if (classify) begin
            mode_in   = MODE_IDLE;
            acc_in    = '0;
            prefix_in = '0;
            len_in    = '0;
            if (in_ch == " " || in_ch == "\t" || in_ch == "\r") begin
               mode_in = MODE_IDLE;
            end else if (in_ch == "\n") begin
               line_in = line_inc;
            end else if (in_ch == "/") begin
               mode_in = MODE_SLASH;
            end else if (in_ch == "=") begin
               mode_in = MODE_EQ;
            end else if (is_digit) begin
               mode_in = MODE_NUMBER;
               acc_in  = NUM_BITS'(digit);
               len_in  = LENGTH_BITS'(1);
            end else if (is_alpha) begin
               mode_in   = MODE_IDENT;
               prefix_in = PREFIX_BITS'(in_ch);
               len_in    = LENGTH_BITS'(1);
            end else begin
               new_en         = 1'b1;
               new_tok.kind   = pkind;
               new_tok.length = LENGTH_BITS'(1);
               if (pkind == KIND_ERROR) begin
                  new_tok.bad = in_ch;
                  mode_in     = MODE_STOP;
               end
            end
         end
      end
   end

   // A flushed token always goes out ahead of the one this beat completes.
   always_comb begin
      tok_count = {1'b0, flush_en} + {1'b0, new_en};
      tok0      = flush_en ? pend_tok : new_tok;
      tok0.last = !(flush_en && new_en);
      tok1      = new_tok;
      tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         acc_ff    <= '0;
         prefix_ff <= '0;
         len_ff    <= '0;
         line_ff   <= LINE_BITS'(1);
      end else if (step) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         prefix_ff <= prefix_in;
         len_ff    <= len_in;
         line_ff   <= line_in;
      end
   end

endmodule

// ----- hw/rtl/sct_token_fifo.sv -----
// Small result queue: takes up to two tokens per cycle, hands out one.
// Depends on sct_pkg and the shared assertion macros.
`include "source_char_tokenizer_assert.svh"

module sct_token_fifo import sct_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    push_count,
   input  sct_token_type push0,
   input  sct_token_type push1,
   output logic          space_ok,
   output logic          out_valid,
   input  logic          out_ready,
   output sct_token_type out_tok
);

   sct_token_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_BITS-1:0]   count_ff;
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_next;
   logic                       pop;

   assign out_valid   = (count_ff != '0);
   assign space_ok    = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign out_tok     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_BITS'(push_count);
         rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_BITS'(pop);
         count_ff  <= count_ff + FIFO_CNT_BITS'(push_count) - FIFO_CNT_BITS'(pop);
      end
   end

   `SCT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH), "result queue overfilled")
   `SCT_ASSERT_NEXT(a_pop_only, clock, reset, pop && push_count == 2'd0, count_ff == $past(count_ff) - 1'b1, "pop without push did not drop the count")
   `SCT_ASSERT_NEXT(a_push_shows, clock, reset, count_ff == '0 && push_count != 2'd0, out_valid, "pushed token not visible")

endmodule
